// ===== hdl/mctp_pkg.sv =====
`default_nettype none

package mctp_pkg;

   // Characters that steer the parser.
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_SERVO_A  = 8'h61;
   localparam logic [7:0] CHAR_SERVO_B  = 8'h62;
   localparam logic [7:0] CHAR_TRAIN    = 8'h74;
   localparam logic [7:0] CHAR_ORIENT   = 8'h6F;
   localparam logic [7:0] CHAR_SCREW    = 8'h73;
   localparam logic [7:0] CHAR_THRESH   = 8'h54;

   // Target codes; each one is also its bit position in the set mask.
   localparam logic [2:0] TGT_SERVO_A   = 3'd0;
   localparam logic [2:0] TGT_SERVO_B   = 3'd1;
   localparam logic [2:0] TGT_TRAIN     = 3'd2;
   localparam logic [2:0] TGT_ORIENT    = 3'd3;
   localparam logic [2:0] TGT_SCREW     = 3'd4;
   localparam logic [2:0] TGT_THRESHOLD = 3'd5;

   // Clamp limits, compared against the signed 16-bit number.
   localparam logic signed [15:0] DUR_MIN   = 16'sd1;
   localparam logic signed [15:0] DUR_MAX   = 16'sd5000;
   localparam logic signed [15:0] SERVO_MIN = 16'sd10;
   localparam logic signed [15:0] SERVO_MAX = 16'sd33;
   localparam logic signed [15:0] VEL_MIN   = -16'sd127;
   localparam logic signed [15:0] VEL_MAX   = 16'sd127;
   localparam logic signed [15:0] THR_MIN   = 16'sd0;
   localparam logic signed [15:0] THR_MAX   = 16'sd255;

   localparam logic [3:0] ERR_MAX = 4'd15;

   // Result queue geometry.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef struct packed {
      logic [12:0]     duration;
      logic            report;
      logic [5:0]      mask;
      logic [5:0]      pos_a;
      logic [5:0]      pos_b;
      logic [2:0][7:0] vel;
      logic [7:0]      threshold;
      logic [3:0]      errors;
   } mctp_action_type;

   typedef struct packed {
      logic [12:0]        duration_ms;
      logic               report;
      logic [5:0]         set_mask;
      logic [5:0]         servo_a_pos;
      logic [5:0]         servo_b_pos;
      logic signed [7:0]  train_velocity;
      logic signed [7:0]  orient_velocity;
      logic signed [7:0]  screw_velocity;
      logic [7:0]         cutoff_threshold;
      logic [3:0]         error_count;
      logic               final_action;
   } mctp_result_type;

   // Up to two results leave the parser for one byte.
   typedef struct packed {
      logic [1:0]      count;
      mctp_result_type first;
      mctp_result_type second;
   } mctp_push_type;

   typedef struct packed {
      logic not_empty;
      logic room;
   } mctp_fifo_status_type;

   function automatic mctp_action_type add_error(mctp_action_type a);
      mctp_action_type r;
      r = a;
      if (a.errors != ERR_MAX) r.errors = a.errors + 4'd1;
      return r;
   endfunction

   function automatic logic signed [15:0] number_value(logic [15:0] acc, logic neg);
      logic [15:0] u;
      u = neg ? 16'(16'd0 - acc) : acc;
      return $signed(u);
   endfunction

   function automatic logic out_of_range(logic signed [15:0] v, logic signed [15:0] lo,
                                         logic signed [15:0] hi);
      return (v < lo) || (v > hi);
   endfunction

   function automatic logic signed [15:0] clamp16(logic signed [15:0] v,
                                                  logic signed [15:0] lo,
                                                  logic signed [15:0] hi);
      logic signed [15:0] r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   function automatic mctp_action_type apply_duration(mctp_action_type a,
                                                      logic signed [15:0] v);
      mctp_action_type r;
      logic signed [15:0] c;
      r = a;
      c = clamp16(v, DUR_MIN, DUR_MAX);
      if (out_of_range(v, DUR_MIN, DUR_MAX)) r = add_error(r);
      r.duration = c[12:0];
      return r;
   endfunction

   function automatic mctp_action_type apply_value(mctp_action_type a, logic [2:0] tgt,
                                                   logic signed [15:0] v);
      mctp_action_type r;
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      logic signed [15:0] c;
      r = a;
      unique case (tgt)
         TGT_SERVO_A, TGT_SERVO_B: begin
            lo = SERVO_MIN;
            hi = SERVO_MAX;
         end
         TGT_TRAIN, TGT_ORIENT, TGT_SCREW: begin
            lo = VEL_MIN;
            hi = VEL_MAX;
         end
         default: begin
            lo = THR_MIN;
            hi = THR_MAX;
         end
      endcase
      c = clamp16(v, lo, hi);
      if (out_of_range(v, lo, hi)) r = add_error(r);
      unique case (tgt)
         TGT_SERVO_A: begin
            r.pos_a = c[5:0];
            r.mask[TGT_SERVO_A] = 1'b1;
         end
         TGT_SERVO_B: begin
            r.pos_b = c[5:0];
            r.mask[TGT_SERVO_B] = 1'b1;
         end
         TGT_TRAIN: begin
            r.vel[0] = c[7:0];
            r.mask[TGT_TRAIN] = 1'b1;
         end
         TGT_ORIENT: begin
            r.vel[1] = c[7:0];
            r.mask[TGT_ORIENT] = 1'b1;
         end
         TGT_SCREW: begin
            r.vel[2] = c[7:0];
            r.mask[TGT_SCREW] = 1'b1;
         end
         default: begin
            r.threshold = c[7:0];
            r.mask[TGT_THRESHOLD] = 1'b1;
         end
      endcase
      return r;
   endfunction

   function automatic mctp_result_type make_result(mctp_action_type a, logic last);
      mctp_result_type r;
      r.duration_ms      = a.duration;
      r.report           = a.report;
      r.set_mask         = a.mask;
      r.servo_a_pos      = a.pos_a;
      r.servo_b_pos      = a.pos_b;
      r.train_velocity   = $signed(a.vel[0]);
      r.orient_velocity  = $signed(a.vel[1]);
      r.screw_velocity   = $signed(a.vel[2]);
      r.cutoff_threshold = a.threshold;
      r.error_count      = a.errors;
      r.final_action     = last;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/mctp_channels.sv =====
`default_nettype none

interface mctp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mctp_rsp_if;
   logic              valid;
   logic              ready;
   logic [12:0]       duration_ms;
   logic              report;
   logic [5:0]        set_mask;
   logic [5:0]        servo_a_pos;
   logic [5:0]        servo_b_pos;
   logic signed [7:0] train_velocity;
   logic signed [7:0] orient_velocity;
   logic signed [7:0] screw_velocity;
   logic [7:0]        cutoff_threshold;
   logic [3:0]        error_count;
   logic              final_action;

   modport source (output valid, output duration_ms, output report, output set_mask,
                   output servo_a_pos, output servo_b_pos, output train_velocity,
                   output orient_velocity, output screw_velocity,
                   output cutoff_threshold, output error_count, output final_action,
                   input ready);
   modport sink (input valid, input duration_ms, input report, input set_mask,
                 input servo_a_pos, input servo_b_pos, input train_velocity,
                 input orient_velocity, input screw_velocity,
                 input cutoff_threshold, input error_count, input final_action,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/mctp_parser.sv =====
`default_nettype none

module mctp_parser import mctp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_take,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output mctp_push_type push
);

   typedef enum logic [2:0] {
      PH_DUR_SIGN,
      PH_DUR_DIGITS,
      PH_VAL_SIGN,
      PH_VAL_DIGITS,
      PH_AFTER,
      PH_DONE
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [15:0]     accum_ff, accum_in;
   logic            neg_ff, neg_in;
   logic [2:0]      target_ff, target_in;
   mctp_action_type action_ff, action_in;

   // State after the byte itself, before any end-of-datagram flush.
   phase_type       ph_a;
   logic [15:0]     acc_a;
   logic            neg_a;
   logic [2:0]      tgt_a;
   mctp_action_type act_a;
   mctp_action_type act_pre;
   logic            emit_v;
   logic            emit_final;
   mctp_action_type emit_act;
   logic            do_peek;
   logic            do_target;

   logic            is_digit;
   logic [3:0]      digit_off;
   logic [15:0]     acc_step;
   logic signed [15:0] cur_val;
   logic signed [15:0] flush_val;

   logic            tgt_hit;
   logic            tgt_bang;
   logic [2:0]      tgt_code;

   logic            flush_emit;
   mctp_action_type flush_act;
   mctp_result_type res_a;
   mctp_result_type res_b;

   assign is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign digit_off = 4'(data_byte - CHAR_ZERO);
   assign acc_step  = (accum_ff << 3) + (accum_ff << 1) + {12'd0, digit_off};
   assign cur_val   = number_value(accum_ff, neg_ff);
   assign flush_val = number_value(acc_a, neg_a);

   always_comb begin
      tgt_hit  = 1'b1;
      tgt_bang = 1'b0;
      tgt_code = TGT_SERVO_A;
      unique case (data_byte)
         CHAR_BANG: begin
            tgt_hit  = 1'b0;
            tgt_bang = 1'b1;
         end
         CHAR_SERVO_A: tgt_code = TGT_SERVO_A;
         CHAR_SERVO_B: tgt_code = TGT_SERVO_B;
         CHAR_TRAIN:   tgt_code = TGT_TRAIN;
         CHAR_ORIENT:  tgt_code = TGT_ORIENT;
         CHAR_SCREW:   tgt_code = TGT_SCREW;
         CHAR_THRESH:  tgt_code = TGT_THRESHOLD;
         default:      tgt_hit  = 1'b0;
      endcase
   end

   // One byte through the phase machine.
   always_comb begin
      ph_a       = phase_ff;
      acc_a      = accum_ff;
      neg_a      = neg_ff;
      tgt_a      = target_ff;
      act_a      = action_ff;
      act_pre    = action_ff;
      emit_v     = 1'b0;
      emit_final = 1'b0;
      emit_act   = action_ff;
      do_peek    = 1'b0;
      do_target  = 1'b0;

      unique case (phase_ff)
         PH_DUR_SIGN, PH_DUR_DIGITS: begin
            if (phase_ff == PH_DUR_SIGN && data_byte == CHAR_MINUS) begin
               neg_a = 1'b1;
               ph_a  = PH_DUR_DIGITS;
            end else if (is_digit) begin
               acc_a = acc_step;
               ph_a  = PH_DUR_DIGITS;
            end else begin
               act_pre   = apply_duration(action_ff, cur_val);
               acc_a     = '0;
               neg_a     = 1'b0;
               do_target = 1'b1;
            end
         end
         PH_VAL_SIGN, PH_VAL_DIGITS: begin
            if (phase_ff == PH_VAL_SIGN && data_byte == CHAR_MINUS) begin
               neg_a = 1'b1;
               ph_a  = PH_VAL_DIGITS;
            end else if (is_digit) begin
               acc_a = acc_step;
               ph_a  = PH_VAL_DIGITS;
            end else begin
               act_pre = apply_value(action_ff, target_ff, cur_val);
               acc_a   = '0;
               neg_a   = 1'b0;
               do_peek = 1'b1;
            end
         end
         PH_AFTER: do_peek = 1'b1;
         default: ;
      endcase

      if (do_peek || do_target) act_a = act_pre;

      // A point where an action may end or the next target may start.
      if (do_peek) begin
         if (data_byte == CHAR_NUL) begin
            emit_v     = 1'b1;
            emit_final = 1'b1;
            emit_act   = act_pre;
            ph_a       = PH_DONE;
         end else if (data_byte == CHAR_COMMA) begin
            emit_v   = 1'b1;
            emit_act = act_pre;
            act_a    = '0;
            acc_a    = '0;
            neg_a    = 1'b0;
            ph_a     = PH_DUR_SIGN;
         end else begin
            do_target = 1'b1;
         end
      end

      if (do_target) begin
         if (tgt_bang) begin
            act_a.report = 1'b1;
            ph_a         = PH_AFTER;
         end else if (tgt_hit) begin
            tgt_a = tgt_code;
            acc_a = '0;
            neg_a = 1'b0;
            ph_a  = PH_VAL_SIGN;
         end else begin
            act_a = add_error(act_pre);
            ph_a  = PH_AFTER;
         end
      end
   end

   // End of datagram: the last byte closes whatever is open and emits the final action.
   always_comb begin
      flush_emit = 1'b0;
      flush_act  = act_a;
      unique case (ph_a)
         PH_DUR_SIGN, PH_DUR_DIGITS: begin
            flush_act  = add_error(apply_duration(act_a, flush_val));
            flush_emit = last_byte;
         end
         PH_VAL_SIGN, PH_VAL_DIGITS: begin
            flush_act  = apply_value(act_a, tgt_a, flush_val);
            flush_emit = last_byte;
         end
         PH_AFTER: flush_emit = last_byte;
         default: ;
      endcase
   end

   assign res_a = make_result(emit_act, emit_final);
   assign res_b = make_result(flush_act, 1'b1);

   always_comb begin
      push.count  = byte_take ? ({1'b0, emit_v} + {1'b0, flush_emit}) : 2'd0;
      push.first  = emit_v ? res_a : res_b;
      push.second = res_b;
   end

   always_comb begin
      if (last_byte) begin
         phase_in  = PH_DUR_SIGN;
         accum_in  = '0;
         neg_in    = 1'b0;
         target_in = TGT_SERVO_A;
         action_in = '0;
      end else begin
         phase_in  = ph_a;
         accum_in  = acc_a;
         neg_in    = neg_a;
         target_in = tgt_a;
         action_in = act_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DUR_SIGN;
         accum_ff  <= '0;
         neg_ff    <= 1'b0;
         target_ff <= TGT_SERVO_A;
         action_ff <= '0;
      end else if (byte_take) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         neg_ff    <= neg_in;
         target_ff <= target_in;
         action_ff <= action_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mctp_rsp_fifo.sv =====
`default_nettype none

module mctp_rsp_fifo import mctp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  mctp_push_type        push,
   input  logic                 pop,
   output mctp_result_type      head,
   output mctp_fifo_status_type status
);

   mctp_result_type        mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_PTR_W-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + RSP_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   assign head             = mem[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   // Room for the worst case of two results from one byte.
   assign status.room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/motion_command_text_parser.sv =====
// Motion command text parser.
// The req_chan channel carries the text payload of an enqueue command, one byte
// per transfer, with last_byte marking the final byte of the datagram. The
// rsp_chan channel carries one transfer per parsed action: duration, report
// flag, set mask, servo positions, motor velocities, cutoff threshold, error
// count and a final-action flag.
// Every byte is handled in the cycle of its transfer: the phase update, the
// multiply by ten of the 16-bit accumulator and the clamping all sit between
// the parser state registers and a four-entry result queue. The byte that
// completes an action writes it into the queue, so the block takes one byte
// per cycle while the queue has room. A byte can complete two actions (a
// separator followed by the end of the datagram); the queue then drains them
// one per cycle while the receiver is ready, and req_chan.ready is low while
// fewer than two queue entries are free. When the receiver stalls, the queue
// fills and req_chan.ready drops; the shown result holds until it is taken.
// Reset empties the queue and returns the parser to the start of a duration
// with an empty action; the parser also returns there after every final byte.
`default_nettype none

module motion_command_text_parser import mctp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   mctp_req_if.sink          req_chan,
   mctp_rsp_if.source        rsp_chan
);

   mctp_push_type        push;
   mctp_result_type      head;
   mctp_fifo_status_type status;
   logic                 byte_take;
   logic                 rsp_take;

   // A byte transfer only happens when the queue can absorb two results.
   assign req_chan.ready = status.room;
   assign byte_take      = req_chan.valid && status.room;
   assign rsp_take       = status.not_empty && rsp_chan.ready;

   mctp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .push      (push)
   );

   mctp_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_take),
      .head   (head),
      .status (status)
   );

   assign rsp_chan.valid            = status.not_empty;
   assign rsp_chan.duration_ms      = head.duration_ms;
   assign rsp_chan.report           = head.report;
   assign rsp_chan.set_mask         = head.set_mask;
   assign rsp_chan.servo_a_pos      = head.servo_a_pos;
   assign rsp_chan.servo_b_pos      = head.servo_b_pos;
   assign rsp_chan.train_velocity   = head.train_velocity;
   assign rsp_chan.orient_velocity  = head.orient_velocity;
   assign rsp_chan.screw_velocity   = head.screw_velocity;
   assign rsp_chan.cutoff_threshold = head.cutoff_threshold;
   assign rsp_chan.error_count      = head.error_count;
   assign rsp_chan.final_action     = head.final_action;

endmodule

`default_nettype wire

// ===== hdl/mctp_checker.sv =====
`default_nettype none

module mctp_checker import mctp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [12:0] rsp_duration_ms,
   input logic [5:0]  rsp_set_mask,
   input logic [5:0]  rsp_servo_a_pos,
   input logic [3:0]  rsp_error_count,
   input logic        rsp_final_action
);

   // A stalled result must stay put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duration_ms)
         && $stable(rsp_set_mask) && $stable(rsp_error_count)
         && $stable(rsp_final_action))
      else $error("result changed while stalled");

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Durations always come out clamped.
   a_duration_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duration_ms >= DUR_MIN[12:0]) && (rsp_duration_ms <= DUR_MAX[12:0]))
      else $error("duration out of range");

   // Servo a reads zero unless set, and then lies within its limits.
   a_servo_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_set_mask[TGT_SERVO_A] && rsp_servo_a_pos == 6'd0)
         || (rsp_set_mask[TGT_SERVO_A] && rsp_servo_a_pos >= SERVO_MIN[5:0]
             && rsp_servo_a_pos <= SERVO_MAX[5:0]))
      else $error("servo a position inconsistent with set mask");

endmodule

bind motion_command_text_parser mctp_checker u_mctp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_duration_ms  (rsp_chan.duration_ms),
   .rsp_set_mask     (rsp_chan.set_mask),
   .rsp_servo_a_pos  (rsp_chan.servo_a_pos),
   .rsp_error_count  (rsp_chan.error_count),
   .rsp_final_action (rsp_chan.final_action)
);

`default_nettype wire
